// ===== hdl/rgbblur_pkg.sv =====
`timescale 1ns / 1ps

package rgbblur_pkg;

  // Field widths fixed by the pixel and result formats.
  localparam int ChW   = 8;
  localparam int PixW  = 3 * ChW;
  localparam int SumW  = 12;
  localparam int PosW  = 10;
  localparam int CfgW  = 11;

  // Configuration register indexes.
  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

  // Bit positions of the pending-result mask, in output order.
  localparam int RES_UP_LEFT = 0;
  localparam int RES_UP      = 1;
  localparam int RES_LEFT    = 2;
  localparam int RES_HERE    = 3;
  localparam int ResN        = 4;

  // Reciprocals for the two non power-of-two neighbor counts.
  localparam int RecipShift = 15;
  localparam logic [12:0] RECIP_6 = 13'd5462;
  localparam logic [12:0] RECIP_9 = 13'd3641;

  // Number of in-frame neighbors of one output pixel.
  typedef enum logic [1:0] {
    CNT_4,
    CNT_6,
    CNT_9
  } cnt_e;

  // One input pixel after the window update, with its pending results.
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic [PosW-1:0]      row;
    logic [PosW-1:0]      col;
    logic [ResN-1:0]      pend;
    logic                 top_ok;
    logic                 left_ok;
  } item_t;

  // Channel sums of one result on their way to the divider.
  typedef struct packed {
    logic [2:0][SumW-1:0] sum;
    cnt_e                 cnt;
    logic [PosW-1:0]      row;
    logic [PosW-1:0]      col;
    logic                 last;
    logic                 done;
  } sum_t;

  // One finished result.
  typedef struct packed {
    logic [ChW-1:0]  blue;
    logic [ChW-1:0]  green;
    logic [ChW-1:0]  red;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            last;
    logic            done;
  } res_t;

  // Truncated mean: divide a channel sum by 4, 6 or 9.
  function automatic logic [ChW-1:0] div_count(input logic [SumW-1:0] s, input cnt_e n);
    logic [24:0]    p;
    logic [ChW-1:0] q;
    p = '0;
    q = '0;
    case (n)
      CNT_4: q = ChW'(s >> 2);
      CNT_6: begin
        p = 25'(s) * 25'(RECIP_6);
        q = p[RecipShift +: ChW];
      end
      CNT_9: begin
        p = 25'(s) * 25'(RECIP_9);
        q = p[RecipShift +: ChW];
      end
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

// ===== hdl/rgbblur_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM with one write port and one registered read port.
module rgbblur_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rgbblur_window.sv =====
`timescale 1ns / 1ps

// Raster counters, two line stores and the 3x3 window.
module rgbblur_window import rgbblur_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int ColW  = $clog2(MAX_WIDTH),
  localparam int RowW  = $clog2(MAX_HEIGHT),
  localparam int WDimW = (CfgW > $clog2(MAX_WIDTH + 1)) ? CfgW : $clog2(MAX_WIDTH + 1),
  localparam int HDimW = (CfgW > $clog2(MAX_HEIGHT + 1)) ? CfgW : $clog2(MAX_HEIGHT + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [WDimW-1:0] w_last_i,
  input  logic [HDimW-1:0] h_last_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [PixW-1:0]  s_axis_tdata,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output item_t            item_o
);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            col_end, row_end, in_fire;

  logic            s1_valid_q, s1_valid_d, s1_adv;
  logic [PixW-1:0] s1_px_q;
  logic [ColW-1:0] s1_addr_q;
  logic [PosW-1:0] s1_row_q, s1_col_q;
  logic [ResN-1:0] s1_pend_q, pend_d;
  logic            s1_top_ok_q, s1_left_ok_q;

  logic [PixW-1:0]      up1, up2;
  logic [8:0][PixW-1:0] win_q, win_d;

  assign col_end = (WDimW'(col_q) == w_last_i);
  assign row_end = (HDimW'(row_q) == h_last_i);
  assign s1_adv  = s1_valid_q && item_ready_i;
  assign s_axis_tready = !s1_valid_q || item_ready_i;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Raster position of the next pixel.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Results released by this pixel, in output order.
  always_comb begin
    pend_d = '0;
    pend_d[RES_UP_LEFT] = (row_q != '0) && (col_q != '0);
    pend_d[RES_UP]      = (row_q != '0) && col_end;
    pend_d[RES_LEFT]    = row_end && (col_q != '0);
    pend_d[RES_HERE]    = row_end && col_end;
  end

  // Stage one control: the pixel waits here for its line store data.
  assign s1_valid_d = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q      <= s_axis_tdata;
      s1_addr_q    <= col_q;
      s1_row_q     <= PosW'(row_q);
      s1_col_q     <= PosW'(col_q);
      s1_pend_q    <= pend_d;
      s1_top_ok_q  <= row_q > RowW'(1);
      s1_left_ok_q <= col_q > ColW'(1);
    end
  end

  // The row above moves into the older store as the held pixel leaves stage one.
  rgbblur_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (up1),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (up2)
  );

  rgbblur_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_px_q),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (up1)
  );

  // Shift the window one column left and load the new right column.
  always_comb begin
    win_d = win_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]     = win_q[k*3+1];
      win_d[k*3 + 1] = win_q[k*3+2];
    end
    win_d[2] = up2;
    win_d[5] = up1;
    win_d[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  assign item_valid_o   = s1_valid_q;
  assign item_o.win     = win_d;
  assign item_o.row     = s1_row_q;
  assign item_o.col     = s1_col_q;
  assign item_o.pend    = s1_pend_q;
  assign item_o.top_ok  = s1_top_ok_q;
  assign item_o.left_ok = s1_left_ok_q;

  // The raster position never leaves the frame.
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WDimW'(col_q) <= w_last_i)
    else $error("column counter past frame width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HDimW'(row_q) <= h_last_i)
    else $error("row counter past frame height");

  // The bottom-right corner also releases the pixels above and to its left.
  a_corner_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_pend_q[RES_HERE] |-> s1_pend_q[RES_UP] && s1_pend_q[RES_LEFT])
    else $error("corner pixel without its edge results");

endmodule

// ===== hdl/rgbblur_emit.sv =====
`timescale 1ns / 1ps

// Issues the pending results of one window one per cycle while the output accepts them: sum, then divide.
module rgbblur_emit import rgbblur_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  output logic  item_ready_o,
  input  item_t item_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  item_t           e_item_q;
  logic [ResN-1:0] e_pend_q, e_pend_d, sel, pend_rest;
  logic            fire, load;

  logic [8:0]           inc;
  logic                 row_top, col_left;
  logic [2:0][SumW-1:0] sums;
  sum_t                 s_q, s_d;
  logic                 s_valid_q, s_ready;
  res_t                 o_q, o_d;
  logic                 o_valid_q, o_ready;

  assign o_ready = !o_valid_q || res_ready_i;
  assign s_ready = !s_valid_q || o_ready;

  // Pick the earliest pending result of the held window.
  assign sel       = e_pend_q & (~e_pend_q + ResN'(1));
  assign pend_rest = e_pend_q & ~sel;
  assign fire      = (e_pend_q != '0) && s_ready;

  assign item_ready_o = (e_pend_q == '0) || (fire && (pend_rest == '0));
  assign load         = item_valid_i && item_ready_o;

  always_comb begin
    e_pend_d = e_pend_q;
    if (load) begin
      e_pend_d = item_i.pend;
    end else if (fire) begin
      e_pend_d = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_pend_q <= '0;
    end else begin
      e_pend_q <= e_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      e_item_q <= item_i;
    end
  end

  // Neighbors that lie in the frame: top row and left column are optional.
  always_comb begin
    row_top  = (sel[RES_UP_LEFT] || sel[RES_UP]) && e_item_q.top_ok;
    col_left = (sel[RES_UP_LEFT] || sel[RES_LEFT]) && e_item_q.left_ok;
    inc = '1;
    if (!row_top) begin
      inc[2:0] = '0;
    end
    if (!col_left) begin
      inc[0] = 1'b0;
      inc[3] = 1'b0;
      inc[6] = 1'b0;
    end
  end

  // Per-channel sums over the selected cells.
  always_comb begin
    sums = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        sums[ch] = sums[ch] + (inc[k] ? SumW'(e_item_q.win[k][ch*ChW +: ChW]) : SumW'(0));
      end
    end
  end

  always_comb begin
    s_d.sum  = sums;
    s_d.cnt  = (row_top && col_left) ? CNT_9 : ((row_top || col_left) ? CNT_6 : CNT_4);
    s_d.row  = (sel[RES_UP_LEFT] || sel[RES_UP]) ? e_item_q.row - PosW'(1) : e_item_q.row;
    s_d.col  = (sel[RES_UP_LEFT] || sel[RES_LEFT]) ? e_item_q.col - PosW'(1) : e_item_q.col;
    s_d.last = (pend_rest == '0);
    s_d.done = sel[RES_HERE];
  end

  // Sum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (s_ready) begin
      s_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s_q <= s_d;
    end
  end

  // Divide by the neighbor count into the output register.
  always_comb begin
    o_d.blue  = div_count(s_q.sum[0], s_q.cnt);
    o_d.green = div_count(s_q.sum[1], s_q.cnt);
    o_d.red   = div_count(s_q.sum[2], s_q.cnt);
    o_d.row   = s_q.row;
    o_d.col   = s_q.col;
    o_d.last  = s_q.last;
    o_d.done  = s_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && s_valid_q) begin
      o_q <= o_d;
    end
  end

  assign res_valid_o = o_valid_q;
  assign res_o       = o_q;

  // Each issued result retires exactly one pending bit.
  a_pend_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !load |=> $countones(e_pend_q) + 1 == $countones($past(e_pend_q)))
    else $error("pending mask did not drop by one result");

  // The frame's final pixel is always the last result of its input.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_q.done |-> o_q.last)
    else $error("frame end not marked as last result");

  // A new window is taken only once the held one has no work left.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (e_pend_q != '0) |-> fire && $onehot(e_pend_q))
    else $error("window replaced with results still pending");

endmodule

// ===== hdl/rgb_box_blur_3x3_top.sv =====
`timescale 1ns / 1ps

// 3x3 box blur over a raster stream of RGB pixels. Each result is the truncated
// per-channel mean of the in-frame neighbors of one pixel (9 inside, 6 on an edge,
// 4 in a corner), tagged with its row and column; tlast marks the last result
// released by an input pixel and tuser marks the frame's bottom-right pixel. A
// pixel is taken every cycle while the output keeps up; results leave one per
// cycle from a single sum-and-divide path, so an input waits on the results it
// releases (0 or 1 inside, up to 2 on the last row or column, 4 at the final
// pixel). An input passes stage one and the emit hold, sum and output registers
// before its first result. Two line stores of MAX_WIDTH x 24 bits hold the prior
// rows; they are not cleared, and entries outside the frame never reach a result.
// Writing either frame register restarts the frame at row 0, column 0; write only
// while idle. Sizes below 2 act as 2 and sizes above the maximum act as the maximum.
module rgb_box_blur_3x3_top import rgbblur_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_addr_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // in_blue, in_green, in_red
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [47:0]     m_axis_tdata,   // out_blue, out_green, out_red, out_row, out_col
  output logic            m_axis_tlast,   // run_last
  output logic [0:0]      m_axis_tuser    // frame_done
);

  localparam int WDimW = (CfgW > $clog2(MAX_WIDTH + 1)) ? CfgW : $clog2(MAX_WIDTH + 1);
  localparam int HDimW = (CfgW > $clog2(MAX_HEIGHT + 1)) ? CfgW : $clog2(MAX_HEIGHT + 1);

  logic [CfgW-1:0]  frame_width_q, frame_width_d;
  logic [CfgW-1:0]  frame_height_q, frame_height_d;
  logic [WDimW-1:0] w_ext, w_eff, w_last;
  logic [HDimW-1:0] h_ext, h_eff, h_last;

  logic  item_valid, item_ready;
  item_t item;
  res_t  res;

  // Frame size registers.
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FRAME_WIDTH:  frame_width_d  = cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(1024);
      frame_height_q <= CfgW'(1024);
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // Clamp the sizes to the supported range and form the last indexes.
  always_comb begin
    w_ext = WDimW'(frame_width_q);
    h_ext = HDimW'(frame_height_q);
    if (w_ext < WDimW'(2)) begin
      w_eff = WDimW'(2);
    end else if (w_ext > WDimW'(MAX_WIDTH)) begin
      w_eff = WDimW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < HDimW'(2)) begin
      h_eff = HDimW'(2);
    end else if (h_ext > HDimW'(MAX_HEIGHT)) begin
      h_eff = HDimW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    w_last = w_eff - WDimW'(1);
    h_last = h_eff - HDimW'(1);
  end

  rgbblur_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (cfg_we_i),
    .w_last_i      (w_last),
    .h_last_i      (h_last),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  rgbblur_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // Pack the result for transfer.
  assign m_axis_tdata = {4'b0000, res.col, res.row, res.red, res.green, res.blue};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.done;

endmodule
